// ===== hdl/rmth_pkg.sv =====
// Package for the running median block: word types, status codes and sizes.
// Used by the top level and the checker; depends on nothing.
package rmth_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_MEDIAN = 1'b1;

  localparam logic [1:0] ST_ADD_OK     = 2'd0;
  localparam logic [1:0] ST_MEDIAN_OK  = 2'd1;
  localparam logic [1:0] ST_ADD_FULL   = 2'd2;
  localparam logic [1:0] ST_MEDIAN_NIL = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic [1:0]         status;
  } out_word_t;

endpackage

// ===== hdl/running_median_two_heaps.sv =====
// Top level of the running median block: handshake, sequencer and the shared
// compare unit. Depends on rmth_pkg and rmth_heap_mem.
//
// The block keeps the lower half of the accepted values in a max-heap and the
// upper half in a min-heap, so the lower median is always the top of the lower
// heap. One word is taken at a time; in_stall is high from acceptance until
// the result has been loaded into the output register. A median request, or
// an add that finds the block full, goes from the upper-top check straight
// to the hand-off state. An add compares the value with the upper heap top
// and, if needed, with the lower heap top. It then runs one sift-up, or a
// replace-top (sift-down) followed by a sift-up in the other heap, and ends
// in a hand-off state for the result. A sift-up step reads the parent, then
// does one compare and one write; at the root the value is written in place.
// A sift-down step reads the left child, then the right child, with two
// compares spread over those reads, and writes one slot; at a leaf the value
// is placed directly. Each heap memory has a single port, and one comparator
// is shared by all steps. A stalled output holds the block in the hand-off
// state while a result waits. Values are kept in offset-binary form so that
// one unsigned comparator orders them. The heaps need no clearing pass: only
// entries below the counts are ever used. The output register holds a finished
// word while the next word is accepted.
module running_median_two_heaps #(
  parameter int CAPACITY   = rmth_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = rmth_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmth_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmth_pkg::out_word_t out_data
);
  import rmth_pkg::*;

  localparam int DEPTH = (CAPACITY + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int HW    = $clog2(DEPTH + 1);
  localparam int VB    = VALUE_BITS;
  localparam int LW    = AW + 2;
  localparam logic [VB-1:0] SGN = {1'b1, {(VB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_U, S_CHK_L, S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R,
    S_DN_CMP, S_DONE
  } state_t;

  state_t          state_r;
  logic [HW-1:0]   lcnt_r, ucnt_r;
  logic            cmd_r;
  logic [VB-1:0]   key_r, cur_r, bestv_r;
  logic            heap_r;      // 1 = lower (max) heap is being worked on
  logic [VB-1:0]   carry_r;     // old top to push into the other heap
  logic [AW-1:0]   idx_r;
  logic            lbest_r;     // left child outranks the value being sifted
  logic            rok_r;       // right child exists
  out_word_t       res_r;
  logic            out_valid_r;
  out_word_t       out_data_r;

  // Memory ports.
  logic            l_we, u_we;
  logic [AW-1:0]   l_addr, u_addr;
  logic [VB-1:0]   l_wd, u_wd, l_rd, u_rd;

  rmth_heap_mem #(.DEPTH(DEPTH), .WIDTH(VB)) u_lower (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
  rmth_heap_mem #(.DEPTH(DEPTH), .WIDTH(VB)) u_upper (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wd), .rdata(u_rd));

  // Shared compare unit: does a rank above b (greater when cmp_hi is set, else smaller).
  logic [VB-1:0] cmp_a, cmp_b;
  logic          cmp_hi;
  logic          cmp_above;
  assign cmp_above = cmp_hi ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  logic [VB-1:0] rd_w;
  assign rd_w = heap_r ? l_rd : u_rd;

  logic [CW-1:0] total_w;
  assign total_w = CW'(lcnt_r) + CW'(ucnt_r);

  // The value field is taken as raw bits and its sign bit is flipped.
  logic [VB-1:0] in_val_w, in_key;
  assign in_val_w = VB'($unsigned(in_data.value));
  assign in_key   = in_val_w ^ SGN;

  logic [31:0] med_w;
  assign med_w = 32'(l_rd ^ SGN);

  // Tree indexes around the current slot.
  logic [HW-1:0] hcnt_w;
  logic [LW-1:0] lidx_w, ridx_w;
  logic [AW-1:0] par_w;
  logic          l_gone_w;
  assign hcnt_w   = heap_r ? lcnt_r : ucnt_r;
  assign lidx_w   = LW'({idx_r, 1'b1});
  assign ridx_w   = lidx_w + LW'(1);
  assign par_w    = (idx_r - AW'(1)) >> 1;
  assign l_gone_w = (lidx_w >= LW'(hcnt_w));

  logic take_r_w;
  assign take_r_w = rok_r && cmp_above;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic out_free, load_out;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  // Compare operands for each step.
  always_comb begin
    cmp_a  = cur_r;
    cmp_b  = rd_w;
    cmp_hi = heap_r;
    case (state_r)
      S_CHK_U: begin
        cmp_a  = key_r;
        cmp_b  = u_rd;
        cmp_hi = 1'b1;
      end
      S_CHK_L: begin
        cmp_a  = key_r;
        cmp_b  = l_rd;
        cmp_hi = 1'b0;
      end
      S_DN_R: begin
        cmp_a = rd_w;
        cmp_b = cur_r;
      end
      S_DN_CMP: begin
        cmp_a = rd_w;
        cmp_b = bestv_r;
      end
      default: cmp_hi = heap_r;
    endcase
  end

  // Memory port selection. Address 0 is read while idle so that both tops
  // are on the read ports when a word has been taken.
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [VB-1:0] m_wd;
  always_comb begin
    m_we   = 1'b0;
    m_addr = '0;
    m_wd   = cur_r;
    case (state_r)
      S_UP_RD: begin
        if (idx_r == '0) begin
          m_we = 1'b1;
        end else begin
          m_addr = par_w;
        end
      end
      S_UP_CMP: begin
        m_we   = 1'b1;
        m_addr = idx_r;
        m_wd   = cmp_above ? rd_w : cur_r;
      end
      S_DN_L: begin
        if (l_gone_w) begin
          m_we   = 1'b1;
          m_addr = idx_r;
        end else begin
          m_addr = lidx_w[AW-1:0];
        end
      end
      S_DN_R:    m_addr = ridx_w[AW-1:0];
      S_DN_CMP: begin
        m_we   = 1'b1;
        m_addr = idx_r;
        m_wd   = take_r_w ? rd_w : (lbest_r ? bestv_r : cur_r);
      end
      default: m_addr = '0;
    endcase
    l_we   = m_we && heap_r;
    u_we   = m_we && !heap_r;
    l_addr = m_addr;
    u_addr = m_addr;
    l_wd   = m_wd;
    u_wd   = m_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcnt_r      <= '0;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (load_out) begin
        out_data_r <= res_r;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data.cmd;
            key_r   <= in_key;
            state_r <= S_CHK_U;
          end
        end
        S_CHK_U: begin
          // Both tops are on the read ports; compare with the upper top.
          if (cmd_r == CMD_MEDIAN) begin
            state_r <= S_DONE;
            if (lcnt_r == '0) begin
              res_r.median <= '0;
              res_r.status <= ST_MEDIAN_NIL;
            end else begin
              res_r.median <= med_w;
              res_r.status <= ST_MEDIAN_OK;
            end
          end else if (total_w >= CW'(CAPACITY)) begin
            res_r.median <= '0;
            res_r.status <= ST_ADD_FULL;
            state_r      <= S_DONE;
          end else begin
            res_r.median <= '0;
            res_r.status <= ST_ADD_OK;
            if ((ucnt_r != '0) && cmp_above) begin
              heap_r <= 1'b0;
              cur_r  <= key_r;
              if (ucnt_r == lcnt_r) begin
                carry_r <= u_rd; idx_r <= '0; state_r <= S_DN_L;
              end else begin
                idx_r <= AW'(ucnt_r); ucnt_r <= ucnt_r + HW'(1);
                state_r <= S_UP_RD;
              end
            end else begin
              state_r <= S_CHK_L;
            end
          end
        end
        S_CHK_L: begin
          // A value equal to a top falls through to the count rule.
          cur_r <= key_r;
          if ((lcnt_r != '0) && cmp_above) begin
            heap_r <= 1'b1;
            if (lcnt_r > ucnt_r) begin
              carry_r <= l_rd; idx_r <= '0; state_r <= S_DN_L;
            end else begin
              idx_r <= AW'(lcnt_r); lcnt_r <= lcnt_r + HW'(1);
              state_r <= S_UP_RD;
            end
          end else if (lcnt_r > ucnt_r) begin
            heap_r <= 1'b0; idx_r <= AW'(ucnt_r); ucnt_r <= ucnt_r + HW'(1);
            state_r <= S_UP_RD;
          end else begin
            heap_r <= 1'b1; idx_r <= AW'(lcnt_r); lcnt_r <= lcnt_r + HW'(1);
            state_r <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          // At the root the value is written in place.
          if (idx_r == '0) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          // Parent data is on rd_w; the parent moves down or the value lands.
          if (cmp_above) begin
            idx_r   <= par_w;
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DN_L: begin
          if (l_gone_w) begin
            // No child left: the value has been placed; push the old top.
            heap_r  <= !heap_r;
            cur_r   <= carry_r;
            state_r <= S_UP_RD;
            if (heap_r) begin
              idx_r <= AW'(ucnt_r); ucnt_r <= ucnt_r + HW'(1);
            end else begin
              idx_r <= AW'(lcnt_r); lcnt_r <= lcnt_r + HW'(1);
            end
          end else begin
            state_r <= S_DN_R;
          end
        end
        S_DN_R: begin
          // Left child data arrives; right child read is in flight.
          bestv_r <= cmp_above ? rd_w : cur_r;
          lbest_r <= cmp_above;
          rok_r   <= (ridx_w < LW'(hcnt_w));
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (take_r_w) begin
            idx_r   <= ridx_w[AW-1:0];
            state_r <= S_DN_L;
          end else if (lbest_r) begin
            idx_r   <= lidx_w[AW-1:0];
            state_r <= S_DN_L;
          end else begin
            heap_r  <= !heap_r;
            cur_r   <= carry_r;
            state_r <= S_UP_RD;
            if (heap_r) begin
              idx_r <= AW'(ucnt_r); ucnt_r <= ucnt_r + HW'(1);
            end else begin
              idx_r <= AW'(lcnt_r); lcnt_r <= lcnt_r + HW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/rmth_heap_mem.sv =====
// One heap store: a single-port memory with registered read data.
// Depends on nothing; the sequencer in the top level drives it.
module rmth_heap_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/rmth_checker.sv =====
// Port-level checker for the running median block, bound to its top level.
// Depends on rmth_pkg.
module rmth_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rmth_pkg::out_word_t out_data
);
  import rmth_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second word while busy");

  a_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_MEDIAN_OK |-> out_data.median == 32'sd0)
    else $error("median field not zero");
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (.*);
